// ===== hdl/request_slot_pool_with_expiry_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the request slot pool
// Shared property wrappers, clocked on aclk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef REQUEST_SLOT_POOL_WITH_EXPIRY_MACROS_SVH
`define REQUEST_SLOT_POOL_WITH_EXPIRY_MACROS_SVH

// Same-cycle implication
`define RSPE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RSPE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rspe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rspe_pkg
// Types, codes and widths shared by the request slot pool modules.
// ---------------------------------------------------------------------------
package rspe_pkg;

    // Default sizing
    localparam int SLOTS_DEF    = 64;
    localparam int GEN_BITS_DEF = 32;

    // Stream word widths
    localparam int S_TDATA_W = 272;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 184;
    localparam int M_TUSER_W = 1;

    // Command codes
    localparam logic [2:0] CMD_RESERVE     = 3'd0;
    localparam logic [2:0] CMD_COMMIT      = 3'd1;
    localparam logic [2:0] CMD_RELEASE     = 3'd2;
    localparam logic [2:0] CMD_LOOKUP      = 3'd3;
    localparam logic [2:0] CMD_POP_EXPIRED = 3'd4;

    // Slot status codes
    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_RESERVED = 2'd1;
    localparam logic [1:0] ST_ACTIVE   = 2'd2;

    // One row of the slot table (generation kept in its own array)
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] tag;
        logic [63:0] due;
    } slot_row_t;

    // Free stack operation
    typedef struct packed {
        logic init;
        logic push;
        logic pop;
    } stk_op_t;

    // Scan unit control
    typedef struct packed {
        logic clear;
        logic feed;
        logic busy;
    } scan_ctl_t;

    // Index width for a table of n entries
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rspe_free_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rspe_free_stack
// LIFO of free slot indices with a depth counter and a registered top read.
// ---------------------------------------------------------------------------
module rspe_free_stack #(
    parameter int SLOTS = rspe_pkg::SLOTS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire rspe_pkg::stk_op_t                      op,
    input  wire logic [rspe_pkg::idx_width(SLOTS)-1:0]  slot_in,  // init index or pushed slot
    output logic      [rspe_pkg::idx_width(SLOTS)-1:0]  top,      // valid the cycle after pop
    output logic      [$clog2(SLOTS+1)-1:0]             depth
);
    import rspe_pkg::*;

    localparam int SLOT_W = idx_width(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    logic [SLOT_W-1:0] stack_mem [SLOTS];
    logic [CNT_W-1:0]  depth_reg, depth_next;
    logic [SLOT_W-1:0] top_reg;
    logic [CNT_W-1:0]  rd_ptr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_ptr;
    logic [SLOT_W-1:0] wr_val;

    assign rd_ptr = depth_reg - CNT_W'(1);

    // Write port and depth update; the clearing pass loads descending indices
    always_comb begin
        depth_next = depth_reg;
        wr_en      = 1'b0;
        wr_ptr     = slot_in;
        wr_val     = slot_in;
        priority if (op.init) begin
            wr_en  = 1'b1;
            wr_val = SLOT_W'(SLOTS - 1) - slot_in;
        end else if (op.push && (depth_reg < CNT_W'(SLOTS))) begin
            wr_en      = 1'b1;
            wr_ptr     = depth_reg[SLOT_W-1:0];
            depth_next = depth_reg + CNT_W'(1);
        end else if (op.pop && (depth_reg != '0)) begin
            depth_next = rd_ptr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= CNT_W'(SLOTS);
        end else begin
            depth_reg <= depth_next;
        end
    end

    // Stack memory, top of stack read every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_ptr] <= wr_val;
        end
        top_reg <= stack_mem[rd_ptr[SLOT_W-1:0]];
    end

    assign top   = top_reg;
    assign depth = depth_reg;

endmodule
`default_nettype wire

// ===== hdl/rspe_scan_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rspe_scan_unit
// Deadline comparator: keeps the earliest due, non-free slot over a row sweep.
// ---------------------------------------------------------------------------
module rspe_scan_unit #(
    parameter int SLOTS = rspe_pkg::SLOTS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire rspe_pkg::scan_ctl_t                    ctl,
    input  wire logic [rspe_pkg::idx_width(SLOTS)-1:0]  entry_idx,
    input  wire logic [63:0]                            entry_due,
    input  wire logic [63:0]                            now,
    output logic                                        found,
    output logic      [rspe_pkg::idx_width(SLOTS)-1:0]  best_idx,
    output logic      [63:0]                            best_due
);
    import rspe_pkg::*;

    localparam int SLOT_W = idx_width(SLOTS);

    logic              found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [63:0]       best_due_reg;
    logic              due_hit;
    logic              better;
    logic              take;

    // Strictly earlier wins, so ties stay with the lower index
    assign due_hit = ctl.busy && (entry_due <= now);
    assign better  = !found_reg || (entry_due < best_due_reg);
    assign take    = ctl.feed && due_hit && better;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg <= entry_idx;
            best_due_reg <= entry_due;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best_due = best_due_reg;

endmodule
`default_nettype wire

// ===== hdl/request_slot_pool_with_expiry.sv =====
// Flow: reserve pops the free stack and writes the popped row; commit/release/
//   lookup read the addressed row first; failed prechecks skip to the result;
//   pop expired reads one table row per cycle, then frees the earliest due slot, if any.
// Throughput: one word at a time; the next word is taken once the result is
//   registered, even while it still waits on m_tready.
// Reset: synchronous on aresetn low; a clearing pass then runs over the slot
//   table and free stack before s_tready first rises.
`timescale 1ns / 1ps
`default_nettype none
`include "request_slot_pool_with_expiry_macros.svh"
// ---------------------------------------------------------------------------
// request_slot_pool_with_expiry
// Generational handle slot pool with LIFO free list and deadline expiry scan.
// ---------------------------------------------------------------------------
module request_slot_pool_with_expiry #(
    parameter int SLOTS    = rspe_pkg::SLOTS_DEF,
    parameter int GEN_BITS = rspe_pkg::GEN_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input words
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // handle_slot[31:0], handle_reserved[47:32], handle_generation[79:48],
    // correlation[143:80], deadline[207:144], now[271:208]
    input  wire logic [rspe_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[2:0]
    input  wire logic [rspe_pkg::S_TUSER_W-1:0]  s_tuser,
    // Result words
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // result_slot[5:0], result_generation[37:6], result_correlation[101:38],
    // result_deadline[165:102], active_total[172:166], free_total[179:173],
    // zero pad[183:180]
    output logic      [rspe_pkg::M_TDATA_W-1:0]  m_tdata,
    // ok[0]
    output logic      [rspe_pkg::M_TUSER_W-1:0]  m_tuser
);
    import rspe_pkg::*;

    localparam int SLOT_W = idx_width(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W:0]    POOL_SIZE = (CNT_W+1)'(SLOTS);

    // Sequencer states
    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_POP  = 4'd3;
    localparam logic [3:0] S_WAIT = 4'd4;
    localparam logic [3:0] S_EXEC = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_SEND = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [31:0]          hs_reg, hs_next;
    logic [15:0]          hr_reg, hr_next;
    logic [31:0]          hg_reg, hg_next;
    logic [63:0]          tag_reg, tag_next;
    logic [63:0]          due_reg, due_next;
    logic [63:0]          now_reg, now_next;
    logic [SLOT_W-1:0]    addr_reg, addr_next;
    logic [CNT_W-1:0]     busy_reg, busy_next;
    logic                 ok_reg, ok_next;
    logic [SLOT_W-1:0]    rslot_reg, rslot_next;
    logic [GEN_BITS-1:0]  rgen_reg, rgen_next;
    logic [63:0]          rtag_reg, rtag_next;
    logic [63:0]          rdue_reg, rdue_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                 feed_reg;

    // Slot table
    slot_row_t            tbl_mem [SLOTS];
    logic [GEN_BITS-1:0]  gen_mem [SLOTS];
    slot_row_t            rd_row_reg;
    logic [GEN_BITS-1:0]  rd_gen_reg;
    logic [SLOT_W-1:0]    rd_idx_reg;
    logic                 tbl_we;
    slot_row_t            tbl_wrow;
    logic                 gen_we;
    logic [GEN_BITS-1:0]  gen_wval;

    // Submodule links
    stk_op_t              stk_op;
    logic [SLOT_W-1:0]    stk_slot;
    logic [SLOT_W-1:0]    stk_top;
    logic [CNT_W-1:0]     stk_depth;
    scan_ctl_t            scan_ctl;
    logic                 scan_found;
    logic [SLOT_W-1:0]    scan_best_idx;
    logic [63:0]          scan_best_due;

    logic                 hs_ok;
    logic                 gen_match;
    logic [GEN_BITS-1:0]  gen_inc;
    logic [GEN_BITS-1:0]  gen_new;

    logic [CNT_W:0]       count_sum;
    logic                 fin_pick;

    rspe_free_stack #(
        .SLOTS (SLOTS)
    ) u_free_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (stk_op),
        .slot_in (stk_slot),
        .top     (stk_top),
        .depth   (stk_depth)
    );

    rspe_scan_unit #(
        .SLOTS (SLOTS)
    ) u_scan_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .entry_idx (rd_idx_reg),
        .entry_due (rd_row_reg.due),
        .now       (now_reg),
        .found     (scan_found),
        .best_idx  (scan_best_idx),
        .best_due  (scan_best_due)
    );

    // Handle checks
    assign hs_ok     = (hg_reg != '0) && (hr_reg == '0) && (hs_reg < 32'(SLOTS));
    assign gen_match = (rd_row_reg.status != ST_FREE) && (32'(rd_gen_reg) == hg_reg);

    // Generation advance, skipping zero
    assign gen_inc = rd_gen_reg + GEN_BITS'(1);
    assign gen_new = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

    // Scan unit feed
    assign scan_ctl.clear = (state_reg == S_DEC) && (cmd_reg == CMD_POP_EXPIRED);
    assign scan_ctl.feed  = feed_reg;
    assign scan_ctl.busy  = (rd_row_reg.status != ST_FREE);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        hs_next       = hs_reg;
        hr_next       = hr_reg;
        hg_next       = hg_reg;
        tag_next      = tag_reg;
        due_next      = due_reg;
        now_next      = now_reg;
        addr_next     = addr_reg;
        busy_next     = busy_reg;
        ok_next       = ok_reg;
        rslot_next    = rslot_reg;
        rgen_next     = rgen_reg;
        rtag_next     = rtag_reg;
        rdue_next     = rdue_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        tbl_we        = 1'b0;
        tbl_wrow      = rd_row_reg;
        gen_we        = 1'b0;
        gen_wval      = gen_new;
        stk_op        = '0;
        stk_slot      = addr_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            // Clearing pass: one row per cycle
            S_INIT: begin
                tbl_we          = 1'b1;
                tbl_wrow.status = ST_FREE;
                tbl_wrow.tag    = '0;
                tbl_wrow.due    = '0;
                gen_we          = 1'b1;
                gen_wval        = '0;
                stk_op.init     = 1'b1;
                if (addr_reg == LAST_IDX) begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end else begin
                    addr_next = addr_reg + SLOT_W'(1);
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser[2:0];
                    hs_next    = s_tdata[31:0];
                    hr_next    = s_tdata[47:32];
                    hg_next    = s_tdata[79:48];
                    tag_next   = s_tdata[143:80];
                    due_next   = s_tdata[207:144];
                    now_next   = s_tdata[271:208];
                    state_next = S_DEC;
                end
            end
            // Command decode and precheck
            S_DEC: begin
                ok_next    = 1'b0;
                rslot_next = '0;
                rgen_next  = '0;
                rtag_next  = '0;
                rdue_next  = '0;
                state_next = S_DONE;
                unique case (cmd_reg)
                    CMD_RESERVE: begin
                        if ((stk_depth != '0) && (due_reg != '0)) begin
                            stk_op.pop = 1'b1;
                            state_next = S_POP;
                        end
                    end
                    CMD_COMMIT, CMD_RELEASE, CMD_LOOKUP: begin
                        if (hs_ok) begin
                            addr_next  = hs_reg[SLOT_W-1:0];
                            state_next = S_WAIT;
                        end
                    end
                    CMD_POP_EXPIRED: begin
                        addr_next  = '0;
                        state_next = S_SCAN;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POP: begin
                addr_next  = stk_top;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                state_next = S_EXEC;
            end
            // Row data is valid: apply the command
            S_EXEC: begin
                state_next = S_DONE;
                unique case (cmd_reg)
                    CMD_RESERVE: begin
                        tbl_we          = 1'b1;
                        tbl_wrow.status = ST_RESERVED;
                        tbl_wrow.tag    = tag_reg;
                        tbl_wrow.due    = due_reg;
                        gen_we          = 1'b1;
                        busy_next       = busy_reg + CNT_W'(1);
                        ok_next         = 1'b1;
                        rslot_next      = addr_reg;
                        rgen_next       = gen_new;
                        rtag_next       = tag_reg;
                        rdue_next       = due_reg;
                    end
                    CMD_COMMIT: begin
                        if (gen_match && (rd_row_reg.status == ST_RESERVED)) begin
                            tbl_we          = 1'b1;
                            tbl_wrow.status = ST_ACTIVE;
                            ok_next         = 1'b1;
                        end
                    end
                    CMD_RELEASE: begin
                        if (gen_match) begin
                            tbl_we          = 1'b1;
                            tbl_wrow.status = ST_FREE;
                            stk_op.push     = 1'b1;
                            if (busy_reg != '0) begin
                                busy_next = busy_reg - CNT_W'(1);
                            end
                            ok_next = 1'b1;
                        end
                    end
                    CMD_LOOKUP: begin
                        if (gen_match) begin
                            ok_next    = 1'b1;
                            rslot_next = addr_reg;
                            rgen_next  = rd_gen_reg;
                            rtag_next  = rd_row_reg.tag;
                            rdue_next  = rd_row_reg.due;
                        end
                    end
                    CMD_POP_EXPIRED: begin
                        tbl_we          = 1'b1;
                        tbl_wrow.status = ST_FREE;
                        stk_op.push     = 1'b1;
                        if (busy_reg != '0) begin
                            busy_next = busy_reg - CNT_W'(1);
                        end
                        ok_next    = 1'b1;
                        rslot_next = addr_reg;
                        rgen_next  = rd_gen_reg;
                        rtag_next  = rd_row_reg.tag;
                        rdue_next  = rd_row_reg.due;
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            // Expiry sweep, one row address per cycle
            S_SCAN: begin
                if (addr_reg == LAST_IDX) begin
                    state_next = S_SEND;
                end else begin
                    addr_next = addr_reg + SLOT_W'(1);
                end
            end
            S_SEND: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (scan_found) begin
                    addr_next  = scan_best_idx;
                    state_next = S_WAIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            // Load the result word once the output register is free
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next           = 1'b1;
                    m_tdata_next            = '0;
                    m_tdata_next[5:0]       = 6'(rslot_reg);
                    m_tdata_next[37:6]      = 32'(rgen_reg);
                    m_tdata_next[101:38]    = rtag_reg;
                    m_tdata_next[165:102]   = rdue_reg;
                    m_tdata_next[172:166]   = 7'(busy_reg);
                    m_tdata_next[179:173]   = 7'(stk_depth);
                    m_tuser_next            = M_TUSER_W'(ok_reg);
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            addr_reg     <= '0;
            busy_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            feed_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            feed_reg     <= (state_reg == S_SCAN);
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        hs_reg      <= hs_next;
        hr_reg      <= hr_next;
        hg_reg      <= hg_next;
        tag_reg     <= tag_next;
        due_reg     <= due_next;
        now_reg     <= now_next;
        ok_reg      <= ok_next;
        rslot_reg   <= rslot_next;
        rgen_reg    <= rgen_next;
        rtag_reg    <= rtag_next;
        rdue_reg    <= rdue_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Slot table memory: one write, one registered read at addr_reg
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[addr_reg] <= tbl_wrow;
        end
        if (gen_we) begin
            gen_mem[addr_reg] <= gen_wval;
        end
        rd_row_reg <= tbl_mem[addr_reg];
        rd_gen_reg <= gen_mem[addr_reg];
        rd_idx_reg <= addr_reg;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Check helpers
    assign count_sum = (CNT_W+1)'(busy_reg) + (CNT_W+1)'(stk_depth);
    assign fin_pick  = (state_reg == S_FIN) && scan_found;

    // Checks
    `RSPE_ASSERT_IMP(a_count_balance, s_tready, count_sum == POOL_SIZE, "counts unbalanced")
    `RSPE_ASSERT_IMP(a_pop_nonempty, stk_op.pop, stk_depth != '0, "pop on empty stack")
    `RSPE_ASSERT_IMP(a_push_room, stk_op.push, stk_depth < CNT_W'(SLOTS), "push on full stack")
    `RSPE_ASSERT_IMP(a_expired_due, fin_pick, scan_best_due <= now_reg, "expiry pick not due")
    `RSPE_ASSERT_NXT(a_accept_decodes, s_tvalid && s_tready, state_reg == S_DEC, "no decode")

endmodule
`default_nettype wire
